[src/sbpu_pkg.sv]
// ----------------------------------------------------------------------------
// sbpu_pkg: shared types and constants of the screen byte pixel unpacker
// Mode codes, register indexes, palette defaults and the command that the
// front end hands to the pixel back end.
// ----------------------------------------------------------------------------
package sbpu_pkg;

	localparam int MAX_BLOCK_ROWS_DEF = 32;
	localparam int PALETTE_ENTRIES    = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_MAP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_ROWS  = 2'd2;

	// display modes
	localparam logic [2:0] MODE0 = 3'd0;
	localparam logic [2:0] MODE1 = 3'd1;
	localparam logic [2:0] MODE2 = 3'd2;
	localparam logic [2:0] MODE4 = 3'd4;
	localparam logic [2:0] MODE5 = 3'd5;

	localparam logic [63:0] PAL_RESET   = 64'h0000_0000_0000_0070;
	localparam logic [7:0]  PAL_DEF_1BP = 8'h70;
	localparam logic [15:0] PAL_DEF_2BP = 16'h7310;
	localparam logic [63:0] PAL_DEF_4BP = 64'hFEDC_BA98_7654_3210;
	localparam logic [5:0]  ROWS_RESET  = 6'd32;

	// last block column of a row
	localparam logic [6:0] COLS_LAST_WIDE   = 7'd79;
	localparam logic [6:0] COLS_LAST_NARROW = 7'd39;

	typedef enum logic [1:0] {
		PK_1BPP,
		PK_2BPP,
		PK_4BPP
	} pix_kind_t;

	// configuration as seen by the datapath
	typedef struct packed {
		logic [63:0] palette;
		pix_kind_t   kind;
		logic [6:0]  cols_last;
		logic [6:0]  rows_eff;
		logic        restart;
	} cfg_t;

	// one byte's worth of pixel work
	typedef struct packed {
		logic [7:0] data;
		logic [6:0] col;
		logic [7:0] y;
		pix_kind_t  kind;
		logic       last_byte;
	} cmd_t;

endpackage

[src/sbpu_byte_if.sv]
// ----------------------------------------------------------------------------
// sbpu_byte_if: screen byte channel
// Valid/ready channel carrying one screen memory byte per beat.
// ----------------------------------------------------------------------------
interface sbpu_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] screen_byte;
	logic       frame_start;

	modport source (output valid, output screen_byte, output frame_start, input ready);
	modport sink   (input valid, input screen_byte, input frame_start, output ready);
endinterface

[src/sbpu_pixel_if.sv]
// ----------------------------------------------------------------------------
// sbpu_pixel_if: pixel channel
// Valid/ready channel carrying one decoded pixel per beat.
// ----------------------------------------------------------------------------
interface sbpu_pixel_if;
	logic       valid;
	logic       ready;
	logic [9:0] pixel_x;
	logic [7:0] pixel_y;
	logic [3:0] pixel_colour;
	logic       byte_done;
	logic       frame_done;

	modport source (output valid, output pixel_x, output pixel_y, output pixel_colour,
		output byte_done, output frame_done, input ready);
	modport sink   (input valid, input pixel_x, input pixel_y, input pixel_colour,
		input byte_done, input frame_done, output ready);
endinterface

[src/sbpu_cfg.sv]
// ----------------------------------------------------------------------------
// sbpu_cfg: configuration registers
// Holds mode, palette and block row count; accepted mode writes reload palette defaults.
// ----------------------------------------------------------------------------
module sbpu_cfg #(
	parameter int MAX_BLOCK_ROWS = sbpu_pkg::MAX_BLOCK_ROWS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sbpu_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sbpu_pkg::CFG_DATA_W-1:0]  cfg_data,
	output sbpu_pkg::cfg_t                   cfg
);
	import sbpu_pkg::*;

	localparam logic [6:0] MAX_ROWS = 7'(MAX_BLOCK_ROWS);

	logic [2:0]  mode_q;
	logic [63:0] palette_q;
	logic [5:0]  rows_q;
	logic [2:0]  wr_mode;
	logic        mode_ok;

	assign wr_mode = cfg_data[2:0];

	always_comb begin
		unique case (wr_mode) inside
			MODE0, MODE1, MODE2, MODE4, MODE5: mode_ok = 1'b1;
			default:                           mode_ok = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE0;
			palette_q <= PAL_RESET;
			rows_q    <= ROWS_RESET;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_SCREEN_MODE: begin
						if (mode_ok) begin
							mode_q <= wr_mode;
							unique case (wr_mode) inside
								MODE1, MODE5: palette_q[15:0] <= PAL_DEF_2BP;
								MODE2:        palette_q       <= PAL_DEF_4BP;
								default:      palette_q[7:0]  <= PAL_DEF_1BP;
							endcase
						end
					end
					CFG_PALETTE_MAP: palette_q <= cfg_data;
					CFG_BLOCK_ROWS:  rows_q    <= cfg_data[5:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		cfg.palette = palette_q;
		// restart the position on the same edge as an accepted mode write
		cfg.restart = cfg_we && (cfg_index == CFG_SCREEN_MODE) && mode_ok;
		unique case (mode_q) inside
			MODE1, MODE5: cfg.kind = PK_2BPP;
			MODE2:        cfg.kind = PK_4BPP;
			default:      cfg.kind = PK_1BPP;
		endcase
		unique case (mode_q) inside
			MODE4, MODE5: cfg.cols_last = COLS_LAST_NARROW;
			default:      cfg.cols_last = COLS_LAST_WIDE;
		endcase
		if (rows_q == 6'd0)
			cfg.rows_eff = 7'd1;
		else if ({1'b0, rows_q} > MAX_ROWS)
			cfg.rows_eff = MAX_ROWS;
		else
			cfg.rows_eff = {1'b0, rows_q};
	end

endmodule

[src/sbpu_front.sv]
// ----------------------------------------------------------------------------
// sbpu_front: byte intake and screen position tracker
// Accepts bytes, keeps the block position, drops bytes past the frame and
// queues a pixel command for every byte that is inside it.
// ----------------------------------------------------------------------------
module sbpu_front #(
	parameter int MAX_BLOCK_ROWS = sbpu_pkg::MAX_BLOCK_ROWS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	sbpu_byte_if.sink       byte_in,
	input  sbpu_pkg::cfg_t  cfg,
	input  logic            q_full,
	output logic            push,
	output sbpu_pkg::cmd_t  push_cmd
);
	import sbpu_pkg::*;

	localparam int RW = (MAX_BLOCK_ROWS > 1) ? $clog2(MAX_BLOCK_ROWS) : 1;

	logic [2:0]    row_q, row_c;
	logic [6:0]    col_q, col_c;
	logic [RW-1:0] bri_q, bri_c;
	logic          done_q, done_c;
	logic          live, last_byte, take;
	logic [RW+2:0] y_full;

	assign byte_in.ready = !q_full;
	assign take          = byte_in.valid && !q_full;

	always_comb begin
		row_c  = byte_in.frame_start ? 3'd0 : row_q;
		col_c  = byte_in.frame_start ? 7'd0 : col_q;
		bri_c  = byte_in.frame_start ? '0 : bri_q;
		done_c = byte_in.frame_start ? 1'b0 : done_q;
		live      = !done_c && (7'(bri_c) < cfg.rows_eff) && (col_c <= cfg.cols_last);
		last_byte = (row_c == 3'd7) && (col_c == cfg.cols_last) &&
			(7'(bri_c) == cfg.rows_eff - 7'd1);
		y_full    = {bri_c, row_c};
	end

	assign push = take && live;

	always_comb begin
		push_cmd.data      = byte_in.screen_byte;
		push_cmd.col       = col_c;
		push_cmd.y         = 8'(y_full);
		push_cmd.kind      = cfg.kind;
		push_cmd.last_byte = last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= 3'd0;
			col_q  <= 7'd0;
			bri_q  <= '0;
			done_q <= 1'b0;
		end else if (cfg.restart) begin
			row_q  <= 3'd0;
			col_q  <= 7'd0;
			bri_q  <= '0;
			done_q <= 1'b0;
		end else if (take) begin
			row_q  <= row_c;
			col_q  <= col_c;
			bri_q  <= bri_c;
			done_q <= done_c;
			if (live) begin
				if (last_byte) begin
					done_q <= 1'b1;
				end else if (row_c != 3'd7) begin
					row_q <= row_c + 3'd1;
				end else begin
					row_q <= 3'd0;
					if (col_c != cfg.cols_last) begin
						col_q <= col_c + 7'd1;
					end else begin
						col_q <= 7'd0;
						bri_q <= bri_c + RW'(1);
					end
				end
			end
		end
	end

endmodule

[src/sbpu_queue.sv]
// ----------------------------------------------------------------------------
// sbpu_queue: two-entry command queue
// Decouples byte intake from pixel generation.
// ----------------------------------------------------------------------------
module sbpu_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sbpu_pkg::cmd_t  push_cmd,
	output logic            full,
	input  logic            pop,
	output sbpu_pkg::cmd_t  pop_cmd,
	output logic            empty
);
	import sbpu_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign pop_cmd = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

[src/sbpu_back.sv]
// ----------------------------------------------------------------------------
// sbpu_back: pixel generator
// Steps through the pixels of one queued byte, one per cycle unless the output
// stalls, maps each through the palette and registers it on the pixel channel.
// ----------------------------------------------------------------------------
module sbpu_back (
	input  logic            clk,
	input  logic            arst_n,
	input  sbpu_pkg::cfg_t  cfg,
	input  logic            q_empty,
	input  sbpu_pkg::cmd_t  q_cmd,
	output logic            pop,
	sbpu_pixel_if.source    pixel_out
);
	import sbpu_pkg::*;

	cmd_t       cur_q;
	logic       cur_v_q;
	logic [2:0] pix_q;
	logic       out_v_q;
	logic [9:0] x_q;
	logic [7:0] y_q;
	logic [3:0] colour_q;
	logic       bdone_q, fdone_q;

	logic       adv, last_pix;
	logic [3:0] idx;
	logic [9:0] x;
	logic [7:0] b;

	assign b   = cur_q.data;
	assign adv = !out_v_q || pixel_out.ready;

	always_comb begin
		unique case (cur_q.kind)
			PK_2BPP: begin
				last_pix = (pix_q == 3'd3);
				idx      = {2'b00, b[3'd7 - pix_q], b[3'd3 - pix_q]};
				x        = {1'b0, cur_q.col, pix_q[1:0]};
			end
			PK_4BPP: begin
				last_pix = (pix_q == 3'd1);
				idx      = {b[3'd7 - pix_q], b[3'd5 - pix_q], b[3'd3 - pix_q],
					b[3'd1 - pix_q]};
				x        = {2'b00, cur_q.col, pix_q[0]};
			end
			default: begin
				last_pix = (pix_q == 3'd7);
				idx      = {3'b000, b[pix_q]};
				x        = {cur_q.col, ~pix_q};
			end
		endcase
	end

	// take the next command when idle or when the current byte finishes
	assign pop = !q_empty && (!cur_v_q || (adv && last_pix));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			pix_q   <= 3'd0;
			out_v_q <= 1'b0;
		end else begin
			if (adv)
				out_v_q <= cur_v_q;
			if (pop) begin
				cur_v_q <= 1'b1;
				pix_q   <= 3'd0;
			end else if (adv && cur_v_q) begin
				if (last_pix)
					cur_v_q <= 1'b0;
				pix_q <= pix_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= q_cmd;
		if (adv && cur_v_q) begin
			x_q      <= x;
			y_q      <= cur_q.y;
			colour_q <= cfg.palette[{idx, 2'b00} +: 4];
			bdone_q  <= last_pix;
			fdone_q  <= last_pix && cur_q.last_byte;
		end
	end

	assign pixel_out.valid        = out_v_q;
	assign pixel_out.pixel_x      = x_q;
	assign pixel_out.pixel_y      = y_q;
	assign pixel_out.pixel_colour = colour_q;
	assign pixel_out.byte_done    = bdone_q;
	assign pixel_out.frame_done   = fdone_q;

endmodule

[src/screen_byte_pixel_unpacker.sv]
// ----------------------------------------------------------------------------
// screen_byte_pixel_unpacker: character-block screen byte to pixel decoder
// Turns screen memory bytes, taken in address order, into palette-mapped
// pixels with x,y coordinates for the one, two and four bit per pixel modes.
// ----------------------------------------------------------------------------
//
//  channel    dir  beat carries                                    handshake
//  ---------  ---  ----------------------------------------------  ---------
//  byte_in    in   screen_byte, frame_start                        valid/ready
//  pixel_out  out  pixel_x, pixel_y, pixel_colour, byte_done,      valid/ready
//                  frame_done
//  cfg_*      in   register index, 64-bit write data               cfg_we only
//
//  A byte yields 8 pixels in modes 0/4, 4 in modes 1/5 and 2 in mode 2; the
//  pixel generator issues one pixel per cycle while the output is not
//  stalled. A byte outside the frame is taken and yields nothing. Two bytes
//  may wait in the command queue while pixels are still held on a stalled
//  output. Reset clears position, queue and output valid; the registers
//  return to mode 0, palette 0x70, 32 block rows.
//
module screen_byte_pixel_unpacker #(
	parameter int MAX_BLOCK_ROWS = sbpu_pkg::MAX_BLOCK_ROWS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	sbpu_byte_if.sink                        byte_in,
	sbpu_pixel_if.source                     pixel_out,
	input  logic                             cfg_we,
	input  logic [sbpu_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sbpu_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import sbpu_pkg::*;

	cfg_t cfg;
	logic q_push, q_pop, q_full, q_empty;
	cmd_t q_in, q_out;

	// registers: mode, palette, block row count; accepted mode writes restart the frame
	sbpu_cfg #(
		.MAX_BLOCK_ROWS(MAX_BLOCK_ROWS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	// front end: track the block position, drop bytes past the frame
	sbpu_front #(
		.MAX_BLOCK_ROWS(MAX_BLOCK_ROWS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_in),
		.cfg     (cfg),
		.q_full  (q_full),
		.push    (q_push),
		.push_cmd(q_in)
	);

	// hold decoded byte commands so intake and output stall on their own
	sbpu_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_cmd(q_in),
		.full    (q_full),
		.pop     (q_pop),
		.pop_cmd (q_out),
		.empty   (q_empty)
	);

	// back end: one pixel per beat through the palette
	sbpu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_empty  (q_empty),
		.q_cmd    (q_out),
		.pop      (q_pop),
		.pixel_out(pixel_out)
	);

endmodule

[tb/sv/tb_screen_byte_pixel_unpacker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_screen_byte_pixel_unpacker: self-checking bench for the pixel unpacker
// Drives screen bytes and register writes, predicts every pixel beat and
// compares each one field by field, under varying source and sink pressure.
// ----------------------------------------------------------------------------
module tb_screen_byte_pixel_unpacker;
	import sbpu_pkg::*;

	localparam int DRAIN_CYCLES   = 24;    // quiet cycles before a register write
	localparam int WATCHDOG_LIMIT = 4000;  // cycles without any beat or write

	// modes the block refuses, and the index that maps to no register
	localparam logic [2:0]           MODE_RSVD3     = 3'd3;
	localparam logic [2:0]           MODE_RSVD6     = 3'd6;
	localparam logic [2:0]           MODE_RSVD7     = 3'd7;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

	typedef struct packed {
		logic [9:0] x;
		logic [7:0] y;
		logic [3:0] colour;
		logic       byte_done;
		logic       frame_done;
	} pixel_t;

	// Pixel prediction and checking: mirrors the register file and the
	// screen position, and queues the pixels each accepted byte must produce.
	class pixel_scoreboard;
		logic [2:0]  mode;
		logic [63:0] palette;
		logic [5:0]  rows;
		logic [2:0]  byte_row;
		logic [6:0]  column;
		logic [5:0]  band;
		bit          complete;
		pixel_t      due_pixels[$];
		int          errors;

		function new();
			mode     = MODE0;
			palette  = PAL_RESET;
			rows     = ROWS_RESET;
			errors   = 0;
			restart();
		endfunction

		function void restart();
			byte_row = '0;
			column   = '0;
			band     = '0;
			complete = 1'b0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
			logic [2:0] m;
			m = data[2:0];
			case (idx)
				CFG_SCREEN_MODE: begin
					if (m == MODE0 || m == MODE4) begin
						palette[7:0] = PAL_DEF_1BP;
					end else if (m == MODE1 || m == MODE5) begin
						palette[15:0] = PAL_DEF_2BP;
					end else if (m == MODE2) begin
						palette = PAL_DEF_4BP;
					end else begin
						return;
					end
					mode = m;
					restart();
				end
				CFG_PALETTE_MAP: palette = data;
				CFG_BLOCK_ROWS:  rows = data[5:0];
				default: ;
			endcase
		endfunction

		function void note_byte(logic [7:0] b, logic fs);
			int     eff, cols, npix, p;
			logic [3:0] idx;
			bit     last;
			pixel_t px;
			if (fs)
				restart();
			eff = rows;
			if (eff < 1)
				eff = 1;
			if (eff > MAX_BLOCK_ROWS_DEF)
				eff = MAX_BLOCK_ROWS_DEF;
			cols = (mode == MODE4 || mode == MODE5) ? 40 : 80;
			if (complete || int'(band) >= eff || int'(column) >= cols)
				return;
			if (mode == MODE1 || mode == MODE5)
				npix = 4;
			else if (mode == MODE2)
				npix = 2;
			else
				npix = 8;
			last = (byte_row == 3'd7) && (int'(column) == cols - 1) && (int'(band) == eff - 1);
			for (p = 0; p < npix; p++) begin
				if (npix == 8) begin
					idx  = {3'b000, b[p]};
					px.x = 10'(int'(column) * 8 + 7 - p);
				end else if (npix == 4) begin
					idx  = {2'b00, b[7-p], b[3-p]};
					px.x = 10'(int'(column) * 4 + p);
				end else begin
					idx  = {b[7-p], b[5-p], b[3-p], b[1-p]};
					px.x = 10'(int'(column) * 2 + p);
				end
				px.y          = 8'(int'(band) * 8 + int'(byte_row));
				px.colour     = palette[int'(idx)*4 +: 4];
				px.byte_done  = (p == npix - 1);
				px.frame_done = (p == npix - 1) && last;
				due_pixels.push_back(px);
			end
			if (last) begin
				complete = 1'b1;
			end else if (byte_row != 3'd7) begin
				byte_row++;
			end else begin
				byte_row = '0;
				if (int'(column) + 1 < cols) begin
					column++;
				end else begin
					column = '0;
					band++;
				end
			end
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t want;
			if (due_pixels.size() == 0) begin
				$error("pixel beat with nothing expected: x %0d y %0d", got.x, got.y);
				errors++;
				return;
			end
			want = due_pixels.pop_front();
			if (got.x !== want.x) begin
				$error("pixel_x: expected %0d, got %0d", want.x, got.x);
				errors++;
			end
			if (got.y !== want.y) begin
				$error("pixel_y: expected %0d, got %0d", want.y, got.y);
				errors++;
			end
			if (got.colour !== want.colour) begin
				$error("pixel_colour: expected %0d, got %0d", want.colour, got.colour);
				errors++;
			end
			if (got.byte_done !== want.byte_done) begin
				$error("byte_done: expected %0d, got %0d", want.byte_done, got.byte_done);
				errors++;
			end
			if (got.frame_done !== want.frame_done) begin
				$error("frame_done: expected %0d, got %0d", want.frame_done, got.frame_done);
				errors++;
			end
		endfunction

		function int outstanding();
			return due_pixels.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sbpu_byte_if  byte_ch ();
	sbpu_pixel_if pix_ch ();

	pixel_scoreboard board = new();

	int send_idle_pct  = 0;   // chance in a hundred of a gap before each byte beat
	int recv_stall_pct = 0;   // chance in a hundred of ready low in a cycle
	int quiet_cycles   = 0;

	screen_byte_pixel_unpacker uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_in   (byte_ch),
		.pixel_out (pix_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// Sink side: check every accepted pixel beat, then pick next cycle's ready.
	always @(posedge clk) begin
		if (arst_n && pix_ch.valid && pix_ch.ready)
			board.check_pixel('{pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.pixel_colour,
				pix_ch.byte_done, pix_ch.frame_done});
		pix_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog: give up once nothing has moved for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_ch.valid && byte_ch.ready) || (pix_ch.valid && pix_ch.ready) || cfg_we)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("screen_byte_pixel_unpacker: mismatch");
				$finish;
			end
		end
	end

	// Drop valid and hold until every predicted pixel has come out, then give
	// bytes that produce nothing time to leave the command queue.
	task automatic settle();
		byte_ch.valid <= 1'b0;
		while (board.outstanding() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write one register while the block is idle; the strobe is held for a
	// single edge and lowered in the step after, so back-to-back calls are safe.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		board.write_reg(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one byte beat, with a random gap in front, and note it on acceptance.
	task automatic send_byte(input logic [7:0] b, input logic fs);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid       <= 1'b1;
		byte_ch.screen_byte <= b;
		byte_ch.frame_start <= fs;
		do
			@(posedge clk);
		while (!byte_ch.ready);
		board.note_byte(b, fs);
	endtask

	task automatic send_burst(input int n);
		repeat (n) send_byte(8'($urandom_range(255)), ($urandom_range(19) == 0));
	endtask

	// Pick the source and sink pressure of one phase.
	task automatic set_pressure(input int ph);
		case (ph)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
			default: begin send_idle_pct = 18; recv_stall_pct = 18; end
		endcase
	endtask

	// Random register set-up; refused modes leave the position running on.
	task automatic random_setup();
		write_reg(CFG_SCREEN_MODE, 64'($urandom_range(7)));
		if ($urandom_range(1))
			write_reg(CFG_PALETTE_MAP, {$urandom, $urandom});
		case ($urandom_range(5))
			0:       write_reg(CFG_BLOCK_ROWS, 64'd0);
			1:       write_reg(CFG_BLOCK_ROWS, 64'd1);
			2:       write_reg(CFG_BLOCK_ROWS, 64'd32);
			3:       write_reg(CFG_BLOCK_ROWS, 64'($urandom_range(33, 63)));
			default: write_reg(CFG_BLOCK_ROWS, 64'($urandom_range(2, 31)));
		endcase
		if ($urandom_range(7) == 0)
			write_reg(CFG_UNUSED_IDX, {$urandom, $urandom});
	endtask

	// Walk the smallest whole frame, a quarter under each pressure phase, then
	// push bytes past its end and restart it.
	task automatic frame_walk();
		write_reg(CFG_SCREEN_MODE, 64'(MODE5));
		write_reg(CFG_PALETTE_MAP, {$urandom, $urandom});
		write_reg(CFG_BLOCK_ROWS, 64'd1);
		for (int ph = 0; ph < 4; ph++) begin
			set_pressure(ph);
			repeat (80) send_byte(8'($urandom_range(255)), 1'b0);
		end
		repeat (3) send_byte(8'($urandom_range(255)), 1'b0);
		send_byte(8'($urandom_range(255)), 1'b1);
		send_burst(3);
	endtask

	initial begin
		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_index           <= '0;
		cfg_data            <= '0;
		byte_ch.valid       <= 1'b0;
		byte_ch.screen_byte <= '0;
		byte_ch.frame_start <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: reset defaults, a restart, every mode at full rate
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hA5, 1'b0);
		send_byte(8'h5A, 1'b1);
		write_reg(CFG_SCREEN_MODE, 64'(MODE1));
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h96, 1'b0);
		send_byte(8'h69, 1'b0);
		write_reg(CFG_SCREEN_MODE, 64'(MODE2));
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h55, 1'b0);
		write_reg(CFG_SCREEN_MODE, 64'(MODE4));
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b0);
		write_reg(CFG_SCREEN_MODE, 64'(MODE5));
		send_byte(8'hC3, 1'b0);
		send_byte(8'h3C, 1'b0);
		// refused modes and the unused index must change nothing
		write_reg(CFG_SCREEN_MODE, 64'(MODE_RSVD3));
		write_reg(CFG_SCREEN_MODE, 64'(MODE_RSVD6));
		write_reg(CFG_SCREEN_MODE, 64'(MODE_RSVD7));
		write_reg(CFG_UNUSED_IDX, 64'hFFFF_FFFF_FFFF_FFFF);
		send_byte(8'hF0, 1'b0);
		// palette extremes in the four bit mode
		write_reg(CFG_SCREEN_MODE, 64'(MODE2));
		write_reg(CFG_PALETTE_MAP, 64'hFFFF_FFFF_FFFF_FFFF);
		send_byte(8'h5A, 1'b0);
		write_reg(CFG_PALETTE_MAP, 64'h0);
		send_byte(8'hFF, 1'b0);
		write_reg(CFG_PALETTE_MAP, 64'h0123_4567_89AB_CDEF);
		send_byte(8'h96, 1'b0);
		write_reg(CFG_BLOCK_ROWS, 64'd0);
		send_byte(8'h01, 1'b0);

		// random: four pressure phases of short bursts, then one whole frame
		for (int ph = 0; ph < 4; ph++) begin
			set_pressure(ph);
			random_setup();
			send_burst($urandom_range(4, 12));
		end
		frame_walk();

		settle();
		if (board.errors == 0 && board.outstanding() == 0)
			$display("screen_byte_pixel_unpacker: match");
		else
			$display("screen_byte_pixel_unpacker: mismatch");
		$finish;
	end
endmodule
